// File: sv/discrete_change_event_unpacker_core_defines.svh
// Assertion macros for the RTL file of the event unpacker.
`ifndef DISCRETE_CHANGE_EVENT_UNPACKER_CORE_DEFINES_SVH
`define DISCRETE_CHANGE_EVENT_UNPACKER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clock edge outside reset.
`define DCEU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define DCEU_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define DCEU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DCEU_ASSERT(lbl, prop, msg)
`define DCEU_ASSERT_IMPL(lbl, ante, cons, msg)
`define DCEU_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: sv/dceu_pkg.sv
`default_nettype none

package dceu_pkg;

    // Fixed field widths of the request and event channels
    localparam int unsigned TICK_W   = 32;
    localparam int unsigned GROUP_W  = 7;
    localparam int unsigned VALUE_W  = 16;
    localparam int unsigned BITNUM_W = 5;

    // Request operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_CHANGE = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SCAN,
        ST_WRITE
    } dceu_state_t;

endpackage

`default_nettype wire

// File: sv/discrete_change_event_unpacker_core.sv
// Load request: taken in ST_IDLE; an in-range start word is written at the accept edge.
// Change request (in-range group, nonzero mask): a fetch state, WORD_BITS scan steps (one mask
// bit per cycle, plus stall cycles while an event waits) and a write-back state; the next
// request is taken only back in ST_IDLE. The first event is registered in the scan step of its
// mask bit, after the fetch and the clear bits below it. The bit-serial scan sets the rate.
// Reset clears the sequencer and the valid flag; the image store is undefined until loaded.
`default_nettype none

`include "discrete_change_event_unpacker_core_defines.svh"

module discrete_change_event_unpacker_core
    import dceu_pkg::*;
#(
    parameter int unsigned GROUP_COUNT = 96,
    parameter int unsigned WORD_BITS   = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // request channel
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire logic                operation,
    input  wire logic [TICK_W-1:0]   tick,
    input  wire logic [GROUP_W-1:0]  group,
    input  wire logic [VALUE_W-1:0]  value,
    // event channel
    output logic                     evt_valid,
    input  wire logic                evt_ready,
    output logic [TICK_W-1:0]        event_tick,
    output logic [GROUP_W-1:0]       event_group,
    output logic [BITNUM_W-1:0]      bit_number,
    output logic                     bit_state,
    output logic                     last
);

    localparam int unsigned AW    = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int unsigned CNT_W = $clog2(WORD_BITS + 1);

    dceu_state_t state_reg, state_next;

    logic [WORD_BITS-1:0]  mem [GROUP_COUNT];
    logic [WORD_BITS-1:0]  mem_rd_reg;
    logic                  mem_we;
    logic [AW-1:0]         mem_wr_addr;
    logic [WORD_BITS-1:0]  mem_wr_data;

    logic [TICK_W-1:0]     tick_reg;
    logic [GROUP_W-1:0]    group_reg;
    logic [WORD_BITS-1:0]  mask_reg, mask_next;
    logic [WORD_BITS-1:0]  img_reg, img_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;

    logic                  evt_valid_reg, evt_valid_next;
    logic [TICK_W-1:0]     evt_tick_reg;
    logic [GROUP_W-1:0]    evt_group_reg;
    logic [BITNUM_W-1:0]   evt_bitnum_reg;
    logic                  evt_state_reg;
    logic                  evt_last_reg;

    logic                  accept;
    logic                  in_range;
    logic [WORD_BITS-1:0]  value_w;
    logic                  out_free;
    logic                  step;
    logic                  emit;
    logic                  new_bit;
    logic                  last_bit;
    logic                  cnt_done;
    logic [CNT_W:0]        bitnum_wide;

    // Decode the request and the scan step
    assign accept      = req_valid && req_ready;
    assign in_range    = (9'(group) < 9'(GROUP_COUNT));
    assign value_w     = WORD_BITS'(value);
    assign out_free    = !evt_valid_reg || evt_ready;
    assign step        = (state_reg == ST_SCAN) && (!mask_reg[0] || out_free);
    assign emit        = step && mask_reg[0];
    assign new_bit     = img_reg[0] ^ mask_reg[0];
    assign last_bit    = ((mask_reg >> 1) == '0);
    assign cnt_done    = (cnt_reg == CNT_W'(WORD_BITS - 1));
    assign bitnum_wide = {1'b0, cnt_reg} + (CNT_W + 1)'(1);

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_range && (operation == OP_CHANGE) && (value_w != '0))
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (step && cnt_done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drive the handshake and the store write port
    always_comb
    begin
        req_ready   = 1'b0;
        mem_we      = 1'b0;
        mem_wr_addr = AW'(group);
        mem_wr_data = ~value_w;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                mem_we    = req_valid && in_range && (operation == OP_LOAD);
            end
            ST_WRITE:
            begin
                mem_we      = 1'b1;
                mem_wr_addr = AW'(group_reg);
                mem_wr_data = img_reg;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // Load the mask and image, then shift the mask and rotate the image word one bit per step
    always_comb
    begin
        mask_next = mask_reg;
        img_next  = img_reg;
        cnt_next  = cnt_reg;
        if (state_reg == ST_FETCH)
        begin
            img_next = mem_rd_reg;
            cnt_next = '0;
        end
        else if (step)
        begin
            mask_next = mask_reg >> 1;
            img_next  = (img_reg >> 1) | (WORD_BITS'(new_bit) << (WORD_BITS - 1));
            cnt_next  = cnt_reg + CNT_W'(1);
        end
        if (accept)
        begin
            mask_next = value_w;
        end
    end

    // Hold the event until it is taken
    always_comb
    begin
        evt_valid_next = evt_valid_reg;
        if (emit)
        begin
            evt_valid_next = 1'b1;
        end
        else if (evt_ready)
        begin
            evt_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            evt_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            evt_valid_reg <= evt_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mask_reg <= mask_next;
        img_reg  <= img_next;
        if (accept)
        begin
            tick_reg  <= tick;
            group_reg <= group;
        end
        if (emit)
        begin
            evt_tick_reg   <= tick_reg;
            evt_group_reg  <= group_reg;
            evt_bitnum_reg <= BITNUM_W'(bitnum_wide);
            evt_state_reg  <= new_bit;
            evt_last_reg   <= last_bit;
        end
    end

    // Group image store: one write port, registered read at accept
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (accept)
        begin
            mem_rd_reg <= mem[AW'(group)];
        end
    end

    assign evt_valid   = evt_valid_reg;
    assign event_tick  = evt_tick_reg;
    assign event_group = evt_group_reg;
    assign bit_number  = evt_bitnum_reg;
    assign bit_state   = evt_state_reg;
    assign last        = evt_last_reg;

    // Checks on the scan sequencer
    `DCEU_ASSERT_IMPL(a_emit_free, emit, out_free, "event overwritten while still pending")
    `DCEU_ASSERT_NEXT(a_fetch_cnt, state_reg == ST_FETCH, cnt_reg == '0, "scan count not cleared")
    `DCEU_ASSERT_NEXT(a_last_mask, emit && last_bit, mask_reg == '0, "events left after last")
    `DCEU_ASSERT_IMPL(a_write_src, mem_we, accept || (state_reg == ST_WRITE), "stray store write")

endmodule

`default_nettype wire

// File: tb/dceu_event_checker.sv
`default_nettype none

module dceu_event_checker
    import dceu_pkg::*;
#(
    parameter int unsigned GROUP_COUNT = 96,
    parameter int unsigned WORD_BITS   = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // request channel
    input  wire logic                req_valid,
    input  wire logic                req_ready,
    input  wire logic                operation,
    input  wire logic [TICK_W-1:0]   tick,
    input  wire logic [GROUP_W-1:0]  group,
    input  wire logic [VALUE_W-1:0]  value,
    // event channel
    input  wire logic                evt_valid,
    input  wire logic                evt_ready,
    input  wire logic [TICK_W-1:0]   event_tick,
    input  wire logic [GROUP_W-1:0]  event_group,
    input  wire logic [BITNUM_W-1:0] bit_number,
    input  wire logic                bit_state,
    input  wire logic                last,
    // status toward the test top
    output int                       mismatch_count,
    output int                       events_due
);

    typedef struct {
        logic [TICK_W-1:0]   evt_tick;
        logic [GROUP_W-1:0]  evt_group;
        logic [BITNUM_W-1:0] bit_num;
        logic                state;
        logic                is_last;
    } bit_event_t;

    // Own copy of the group image store and the events still owed by the block
    logic [WORD_BITS-1:0] image_word [GROUP_COUNT];
    bit_event_t           owed_events [$];
    bit_event_t           oldest_event;
    int                   mismatches = 0;

    assign mismatch_count = mismatches;

    task automatic report_mismatch(input string field, input longint got, input longint want);
        mismatches++;
        $display("[%0t] event %s: got %0h, want %0h", $time, field, got, want);
    endtask

    // Update the image store and queue one event per set mask bit, lowest first
    task automatic unpack_request(
        input logic                op,
        input logic [TICK_W-1:0]   t,
        input logic [GROUP_W-1:0]  g,
        input logic [VALUE_W-1:0]  v
    );
        logic [WORD_BITS-1:0] word;
        logic [WORD_BITS-1:0] mask;
        bit_event_t           evt;
        int                   b;
        mask = v[WORD_BITS-1:0];
        // out-of-range groups are dropped without touching the store
        if (g >= GROUP_COUNT)
            return;
        if (op == OP_LOAD)
        begin
            image_word[g] = ~mask;
            return;
        end
        word = image_word[g];
        for (b = 0; b < WORD_BITS; b++)
        begin
            if (mask[b])
            begin
                word[b]       = ~word[b];
                evt.evt_tick  = t;
                evt.evt_group = g;
                evt.bit_num   = BITNUM_W'(b + 1);
                evt.state     = word[b];
                evt.is_last   = ((mask >> (b + 1)) == 0);
                owed_events.push_back(evt);
            end
        end
        image_word[g] = word;
    endtask

    // Check events before predicting, so a stray event never pairs with a fresh request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (evt_valid && evt_ready)
            begin
                if (owed_events.size() == 0)
                    report_mismatch("with none outstanding, bit", bit_number, 0);
                else
                begin
                    oldest_event = owed_events.pop_front();
                    if (event_tick !== oldest_event.evt_tick)
                        report_mismatch("tick", event_tick, oldest_event.evt_tick);
                    if (event_group !== oldest_event.evt_group)
                        report_mismatch("group", event_group, oldest_event.evt_group);
                    if (bit_number !== oldest_event.bit_num)
                        report_mismatch("bit_number", bit_number, oldest_event.bit_num);
                    if (bit_state !== oldest_event.state)
                        report_mismatch("bit_state", bit_state, oldest_event.state);
                    if (last !== oldest_event.is_last)
                        report_mismatch("last", last, oldest_event.is_last);
                end
            end
            if (req_valid && req_ready)
                unpack_request(operation, tick, group, value);
        end
        // Publish how many events are still owed
        events_due = owed_events.size();
    end

endmodule

`default_nettype wire

// File: tb/discrete_change_event_unpacker_core_test.sv
`default_nettype none

module discrete_change_event_unpacker_core_test;
    import dceu_pkg::*;

    localparam int unsigned GROUP_COUNT    = 96;
    localparam int unsigned WORD_BITS      = 16;
    localparam int          RANDOM_ITEMS   = 280;
    localparam int          STEADY_ITEMS   = 40;
    localparam int          SETTLE_CYCLES  = 40;
    localparam int          WATCHDOG_LIMIT = 3000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    logic                operation = OP_LOAD;
    logic [TICK_W-1:0]   tick = '0;
    logic [GROUP_W-1:0]  group = '0;
    logic [VALUE_W-1:0]  value = '0;
    logic                evt_valid;
    logic                evt_ready = 1'b0;
    logic [TICK_W-1:0]   event_tick;
    logic [GROUP_W-1:0]  event_group;
    logic [BITNUM_W-1:0] bit_number;
    logic                bit_state;
    logic                last;
    int                  mismatch_count;
    int                  events_due;

    // Stimulus-side bookkeeping: which groups hold a start word
    bit                  group_loaded [GROUP_COUNT];
    bit                  steady_tail = 1'b0;
    bit                  stalls_on = 1'b0;
    int                  stall_left = 0;
    int                  mode_left = 0;
    int                  quiet_cycles = 0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    discrete_change_event_unpacker_core #(
        .GROUP_COUNT (GROUP_COUNT),
        .WORD_BITS   (WORD_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .operation   (operation),
        .tick        (tick),
        .group       (group),
        .value       (value),
        .evt_valid   (evt_valid),
        .evt_ready   (evt_ready),
        .event_tick  (event_tick),
        .event_group (event_group),
        .bit_number  (bit_number),
        .bit_state   (bit_state),
        .last        (last)
    );

    dceu_event_checker #(
        .GROUP_COUNT (GROUP_COUNT),
        .WORD_BITS   (WORD_BITS)
    ) event_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .operation      (operation),
        .tick           (tick),
        .group          (group),
        .value          (value),
        .evt_valid      (evt_valid),
        .evt_ready      (evt_ready),
        .event_tick     (event_tick),
        .event_group    (event_group),
        .bit_number     (bit_number),
        .bit_state      (bit_state),
        .last           (last),
        .mismatch_count (mismatch_count),
        .events_due     (events_due)
    );

    // Switch event stalls on and off so some stretches run without any
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stalls_on <= ($urandom_range(0, 2) != 0);
            mode_left <= $urandom_range(20, 80);
        end
        else
            mode_left <= mode_left - 1;
    end

    // Drop evt_ready in bursts, at random while stalls are on and the steady tail has not begun
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            evt_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (stalls_on && !steady_tail && $urandom_range(0, 7) == 0)
        begin
            evt_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 10);
        end
        else
            evt_ready <= 1'b1;
    end

    // End the run when nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (evt_valid && evt_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Present one request and hold it until the block takes it
    task automatic send_request(
        input logic                op,
        input logic [TICK_W-1:0]   t,
        input logic [GROUP_W-1:0]  g,
        input logic [VALUE_W-1:0]  v
    );
        @(negedge clk);
        req_valid <= 1'b1;
        operation <= op;
        tick      <= t;
        group     <= g;
        value     <= v;
        do
            @(posedge clk);
        while (!req_ready);
        if (op == OP_LOAD && g < GROUP_COUNT)
            group_loaded[g] = 1'b1;
    endtask

    task automatic hold_off(input int cycles);
        @(negedge clk);
        req_valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Hold requests until every owed event has come out
    task automatic drain_events();
        @(negedge clk);
        req_valid <= 1'b0;
        while (events_due != 0)
            @(negedge clk);
    endtask

    initial
    begin
        logic [GROUP_W-1:0] g;
        logic [VALUE_W-1:0] mask;
        int                 pick;
        int                 n;
        bit                 gaps_on;

        gaps_on = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extremes of every field, zero mask, out-of-range groups
        send_request(OP_LOAD,   32'h0000_0000, 7'd0,   16'h0000);
        send_request(OP_LOAD,   32'hFFFF_FFFF, 7'd95,  16'hFFFF);
        send_request(OP_LOAD,   32'h1234_5678, 7'd127, 16'h0F0F);
        send_request(OP_LOAD,   32'h0000_0001, 7'd96,  16'h1111);
        send_request(OP_LOAD,   32'h0000_0002, 7'd1,   16'h1234);
        send_request(OP_CHANGE, 32'h0000_0000, 7'd0,   16'hFFFF);
        send_request(OP_CHANGE, 32'hFFFF_FFFF, 7'd95,  16'hFFFF);
        send_request(OP_CHANGE, 32'h8000_0000, 7'd0,   16'h0001);
        send_request(OP_CHANGE, 32'h0000_0003, 7'd0,   16'h8000);
        send_request(OP_CHANGE, 32'h0000_0004, 7'd1,   16'h0000);
        send_request(OP_CHANGE, 32'h0000_0005, 7'd96,  16'hFFFF);
        send_request(OP_CHANGE, 32'hAAAA_5555, 7'd127, 16'h5555);
        send_request(OP_LOAD,   32'h0000_0006, 7'd0,   16'hA5A5);
        send_request(OP_CHANGE, 32'h5555_AAAA, 7'd0,   16'h5A5A);
        send_request(OP_CHANGE, 32'h7FFF_FFFF, 7'd1,   16'hAAAA);
        send_request(OP_CHANGE, 32'h0000_0007, 7'd95,  16'h0180);
        send_request(OP_LOAD,   32'h0000_0008, 7'd64,  16'hC3C3);
        send_request(OP_CHANGE, 32'h0000_0009, 7'd64,  16'h4001);
        drain_events();

        // Random: mostly change records on loaded groups, some loads and strays
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS - STEADY_ITEMS)
                steady_tail = 1'b1;
            if (n % 25 == 0)
                gaps_on = ($urandom_range(0, 1) != 0);
            if (n == RANDOM_ITEMS / 2)
                drain_events();
            if (gaps_on && !steady_tail && $urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 11));

            pick = $urandom_range(0, 99);
            g    = (pick < 50) ? GROUP_W'($urandom_range(0, 7))
                               : GROUP_W'($urandom_range(0, GROUP_COUNT - 1));
            case ($urandom_range(0, 9))
                0:       mask = '0;
                1:       mask = '1;
                2:       mask = VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
                default: mask = VALUE_W'($urandom_range(0, 65535));
            endcase

            if (pick >= 95)
                send_request(logic'($urandom_range(0, 1)), $urandom(),
                             GROUP_W'($urandom_range(GROUP_COUNT, 127)), mask);
            else if (pick < 15 || !group_loaded[g])
                send_request(OP_LOAD, $urandom(), g, VALUE_W'($urandom_range(0, 65535)));
            else
                send_request(OP_CHANGE, $urandom(), g, mask);
        end

        // Let the block finish, then give the verdict
        drain_events();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+sv
sv/dceu_pkg.sv
sv/discrete_change_event_unpacker_core.sv
tb/dceu_event_checker.sv
tb/discrete_change_event_unpacker_core_test.sv
